// ===== hw/rtl/aft_pkg.sv =====
// ============================================================================
// aft_pkg: shared types and constants for the ACES filmic tone mapper
// Pixel word structs, fixed-point widths and curve coefficients.
// ============================================================================
package aft_pkg;

    localparam int unsigned CH_W    = 16;  // Q8.8 channel
    localparam int unsigned OUT_W   = 13;  // Q1.12 result, 4096 = 1.0
    localparam int unsigned T_W     = 24;  // linear terms 251x+768, 243x+15104
    localparam int unsigned NUM_W   = 40;  // x*(251x+768)
    localparam int unsigned DEN_W   = 41;  // x*(243x+15104)+917504
    localparam int unsigned DIV_STG = 13;  // one quotient bit per stage
    localparam int unsigned LANE_LAT = 2 + DIV_STG;

    localparam logic [7:0]        C_NUM_A = 8'd251;
    localparam logic [9:0]        C_NUM_B = 10'd768;
    localparam logic [7:0]        C_DEN_A = 8'd243;
    localparam logic [13:0]       C_DEN_B = 14'd15104;
    localparam logic [DEN_W-1:0]  C_DEN_C = 41'd917504;
    localparam logic [OUT_W-1:0]  ONE_Q12 = 13'd4096;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [OUT_W-1:0] red_out;
        logic [OUT_W-1:0] green_out;
        logic [OUT_W-1:0] blue_out;
        logic [CH_W-1:0]  alpha_out;
    } t_pix_out;

endpackage

// ===== hw/rtl/aft_lane.sv =====
// ============================================================================
// aft_lane: one color channel of the tone curve
// Polynomial terms, products, then a 13-stage restoring divider.
// ============================================================================
module aft_lane (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [aft_pkg::CH_W-1:0]        i_x,
    output logic [aft_pkg::OUT_W-1:0]       o_q
);

    localparam int unsigned NS = aft_pkg::DIV_STG;

    logic [aft_pkg::CH_W-1:0]  r_x;
    logic [aft_pkg::T_W-1:0]   r_tn, r_td;
    logic [aft_pkg::NUM_W-1:0] r_num;
    logic [aft_pkg::DEN_W-1:0] r_den0;

    logic [aft_pkg::DEN_W-1:0] r_rem [NS];
    logic [aft_pkg::DEN_W-1:0] r_den [NS];
    logic [aft_pkg::OUT_W-1:0] r_q   [NS];

    // stage 1: linear terms (constant multiplies)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= i_x;
            r_tn <= aft_pkg::T_W'(i_x) * aft_pkg::T_W'(aft_pkg::C_NUM_A)
                    + aft_pkg::T_W'(aft_pkg::C_NUM_B);
            r_td <= aft_pkg::T_W'(i_x) * aft_pkg::T_W'(aft_pkg::C_DEN_A)
                    + aft_pkg::T_W'(aft_pkg::C_DEN_B);
        end
    end

    // stage 2: numerator and denominator products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= aft_pkg::NUM_W'(r_x) * aft_pkg::NUM_W'(r_tn);
            r_den0 <= aft_pkg::DEN_W'(r_x) * aft_pkg::DEN_W'(r_td) + aft_pkg::C_DEN_C;
        end
    end

    // divide stages: remainder stays below den, so shifting keeps DEN_W+1 bits
    for (genvar k = 0; k < NS; k++) begin : g_div
        logic [aft_pkg::DEN_W:0]   w_a;
        logic [aft_pkg::DEN_W:0]   w_d;
        logic [aft_pkg::OUT_W-1:0] w_qp;
        logic [aft_pkg::DEN_W-1:0] w_dp;
        logic                      w_ge;

        if (k == 0) begin : g_first
            assign w_a  = (aft_pkg::DEN_W+1)'(r_num);
            assign w_qp = '0;
            assign w_dp = r_den0;
        end else begin : g_rest
            assign w_a  = {r_rem[k-1], 1'b0};
            assign w_qp = r_q[k-1];
            assign w_dp = r_den[k-1];
        end
        assign w_d  = {1'b0, w_dp};
        assign w_ge = (w_a >= w_d);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? aft_pkg::DEN_W'(w_a - w_d) : aft_pkg::DEN_W'(w_a);
                r_den[k] <= w_dp;
                r_q[k]   <= {w_qp[aft_pkg::OUT_W-2:0], w_ge};
            end
        end
    end

    assign o_q = r_q[NS-1];

endmodule

// ===== hw/rtl/aces_filmic_tonemap.sv =====
// ============================================================================
// aces_filmic_tonemap: ACES filmic tone curve, one pixel per clock unless stalled
// Three channel lanes in parallel, alpha delayed alongside, clamp and merge
// into a registered output word.
// ============================================================================
//  channel | valid   | stall   | word
//  --------+---------+---------+---------------------------
//  input   | i_valid | o_stall | i_word (aft_pkg::t_pix_in)
//  output  | o_valid | i_stall | o_word (aft_pkg::t_pix_out)
//
//  Throughput one word per clock while the output is not stalled; the path runs
//  through 2 term/product stages, 13 divider stages and 1 output register.
//  Reset clears only the valid pipeline; data registers are not reset.
//  The whole pipeline freezes while a valid output word is stalled; bubbles
//  are not squeezed out, so the input stalls whenever the output word is held.
// ============================================================================
module aces_filmic_tonemap (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  aft_pkg::t_pix_in  i_word,
    output logic              o_valid,
    input  logic              i_stall,
    output aft_pkg::t_pix_out o_word
);

    localparam int unsigned LAT = aft_pkg::LANE_LAT;

    logic                      w_en;
    logic [LAT-1:0]            r_vld;
    logic [aft_pkg::CH_W-1:0]  r_alpha [LAT];
    logic [aft_pkg::OUT_W-1:0] w_q [3];
    logic [aft_pkg::CH_W-1:0]  w_x [3];
    logic                      r_ovld;
    aft_pkg::t_pix_out         r_oword;

    // advance unless a finished word is held by the sink
    assign w_en    = !(r_ovld && i_stall);
    assign o_stall = !w_en;

    assign w_x[0] = i_word.red_in;
    assign w_x[1] = i_word.green_in;
    assign w_x[2] = i_word.blue_in;

    for (genvar c = 0; c < 3; c++) begin : g_lane
        aft_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_x[c]),
            .o_q   (w_q[c])
        );
    end

    // valid bits track the lanes' data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld  <= {r_vld[LAT-2:0], i_valid};
            r_ovld <= r_vld[LAT-1];
        end
    end

    // alpha rides along untouched
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_alpha[0] <= i_word.alpha_in;
            for (int i = 1; i < LAT; i++) begin
                r_alpha[i] <= r_alpha[i-1];
            end
        end
    end

    // merge: clamp each lane to 1.0 and register the output word
    function automatic logic [aft_pkg::OUT_W-1:0] f_sat(input logic [aft_pkg::OUT_W-1:0] q);
        return (q > aft_pkg::ONE_Q12) ? aft_pkg::ONE_Q12 : q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_oword.red_out   <= f_sat(w_q[0]);
            r_oword.green_out <= f_sat(w_q[1]);
            r_oword.blue_out  <= f_sat(w_q[2]);
            r_oword.alpha_out <= r_alpha[LAT-1];
        end
    end

    assign o_valid = r_ovld;
    assign o_word  = r_oword;

    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[LAT-1]) |=> o_valid)
        else $error("finished word not delivered to output");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word.red_out <= aft_pkg::ONE_Q12 &&
                     o_word.green_out <= aft_pkg::ONE_Q12 &&
                     o_word.blue_out <= aft_pkg::ONE_Q12))
        else $error("channel above 1.0");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved while frozen");

endmodule

// ===== tb/tonemap_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tonemap_checker: scoreboard for the ACES filmic tone mapper
// Watches both channels, predicts each output word from the accepted input
// word with exact integer arithmetic, and compares in order.
// ============================================================================
module tonemap_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall_in,
    input  aft_pkg::t_pix_in  i_word,
    input  logic              i_valid_out,
    input  logic              i_stall,
    input  aft_pkg::t_pix_out i_word_out,
    output int                o_errors,
    output int                o_pending
);

    aft_pkg::t_pix_out expected_pixels[$];

    // floor(4096*num/den) of the rational curve, saturated at 1.0
    function automatic logic [aft_pkg::OUT_W-1:0] tone_curve(
        input logic [aft_pkg::CH_W-1:0] x);
        logic [63:0] xv, num, den, q;
        xv  = 64'(x);
        num = xv * (64'd251 * xv + 64'd768);
        den = xv * (64'd243 * xv + 64'd15104) + 64'd917504;
        q   = (num * 64'd4096) / den;
        if (q > 64'd4096) q = 64'd4096;
        return q[aft_pkg::OUT_W-1:0];
    endfunction

    function automatic aft_pkg::t_pix_out map_pixel(input aft_pkg::t_pix_in p);
        aft_pkg::t_pix_out r;
        r.red_out   = tone_curve(p.red_in);
        r.green_out = tone_curve(p.green_in);
        r.blue_out  = tone_curve(p.blue_in);
        r.alpha_out = p.alpha_in;
        return r;
    endfunction

    assign o_pending = expected_pixels.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        aft_pkg::t_pix_out exp_w;
        if (i_rst_n) begin
            if (i_valid && !i_stall_in)
                expected_pixels = {expected_pixels, map_pixel(i_word)};
            if (i_valid_out && !i_stall) begin
                if (expected_pixels.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected output word %h", i_word_out);
                end else begin
                    exp_w = expected_pixels.pop_front();
                    if (exp_w !== i_word_out) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: exp r%0d g%0d b%0d a%h got r%0d g%0d b%0d a%h",
                                exp_w.red_out, exp_w.green_out, exp_w.blue_out,
                                exp_w.alpha_out, i_word_out.red_out,
                                i_word_out.green_out, i_word_out.blue_out,
                                i_word_out.alpha_out);
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb: testbench for aces_filmic_tonemap
// Directed corner pixels then random pixels with random idle on both sides
// and one long output hold-off; a checker module scores every output word.
// ============================================================================
module tb;

    localparam int NUM_RANDOM = 1480;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    aft_pkg::t_pix_in  in_word;
    logic              out_valid;
    logic              out_stall;
    aft_pkg::t_pix_out out_word;
    int                errors;
    int                pending;
    logic              hold_off;      // long receiver hold-off, owned by its own process
    logic              quiet_phase;   // no random idling on either side
    logic              rand_stall;

    aces_filmic_tonemap dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_word  (in_word),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_word  (out_word)
    );

    tonemap_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .i_stall_in  (in_stall),
        .i_word      (in_word),
        .i_valid_out (out_valid),
        .i_stall     (out_stall),
        .i_word_out  (out_word),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2000000;
        $display("aces_filmic_tonemap test failed");
        $finish;
    end

    assign out_stall = hold_off | rand_stall;

    // receiver: random stalls, off during the quiet stretch
    always @(posedge clk) begin
        rand_stall <= !quiet_phase && ($urandom_range(99) < 10);
    end

    // channel value biased toward the interesting ranges of the curve
    function automatic logic [aft_pkg::CH_W-1:0] rand_channel();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(255));      // below 1.0
            1:       return 16'($urandom_range(4095));     // up to 16.0
            2:       return 16'($urandom_range(65535, 65000));
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one word, with optional idle cycles ahead of it, until accepted
    task automatic send_pixel(input aft_pkg::t_pix_in p);
        while (!quiet_phase && $urandom_range(99) < 10) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_rgb(input logic [aft_pkg::CH_W-1:0] r, g, b, a);
        aft_pkg::t_pix_in p;
        p.red_in = r; p.green_in = g; p.blue_in = b; p.alpha_in = a;
        send_pixel(p);
    endtask

    initial begin
        aft_pkg::t_pix_in p;
        in_valid    = 1'b0;
        in_word     = '0;
        hold_off    = 1'b0;
        quiet_phase = 1'b0;
        rst_n       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, tiny values, around 1.0, saturation, all ones
        send_rgb(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_rgb(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_rgb(16'h0001, 16'h0002, 16'h0003, 16'hA5A5);
        send_rgb(16'h0100, 16'h0080, 16'h0040, 16'h5A5A);
        send_rgb(16'h0200, 16'h0400, 16'h0800, 16'h0001);
        send_rgb(16'h1000, 16'h2000, 16'h4000, 16'h8000);
        send_rgb(16'h8000, 16'h7FFF, 16'hFFFE, 16'h7FFF);
        send_rgb(16'h00FF, 16'h0101, 16'h0C00, 16'hFFFE);
        send_rgb(16'h5555, 16'hAAAA, 16'h1234, 16'hAAAA);
        send_rgb(16'h0A00, 16'h1400, 16'h3200, 16'h5555);
        send_rgb(16'hFF00, 16'h00FF, 16'h0F0F, 16'hF0F0);

        // long hold-off: sender keeps offering, the pipeline fills and stalls
        fork
            begin
                hold_off <= 1'b1;
                repeat (120) @(posedge clk);
                hold_off <= 1'b0;
            end
            for (int i = 0; i < 60; i++) begin
                p = {rand_channel(), rand_channel(), rand_channel(), 16'($urandom)};
                send_pixel(p);
            end
        join

        for (int i = 0; i < NUM_RANDOM; i++) begin
            quiet_phase <= (i >= 400 && i < 700);   // stretch with no idling
            p = {rand_channel(), rand_channel(), rand_channel(), 16'($urandom)};
            send_pixel(p);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("aces_filmic_tonemap test passed");
        else
            $display("aces_filmic_tonemap test failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/aft_pkg.sv
hw/rtl/aft_lane.sv
hw/rtl/aces_filmic_tonemap.sv
tb/tonemap_checker.sv
tb/tb.sv
